@@ rtl/altrk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package altrk_pkg;

    // Table size and client count.
    localparam int TABLE_ENTRIES = 32;
    localparam int NUM_CLIENTS   = 4;

    // Fixed field widths.
    localparam int CMD_W    = 2;
    localparam int CLIENT_W = 2;
    localparam int ADDR_W   = 64;
    localparam int CODE_W   = 4;

    // Counter widths that follow from the sizes above.
    localparam int STEP_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SCLI_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd2;

    // Result codes.
    localparam logic [CODE_W-1:0] EV_ALLOC_OK       = 4'd0;
    localparam logic [CODE_W-1:0] EV_REALLOC_LIVE   = 4'd1;
    localparam logic [CODE_W-1:0] EV_FREE_OK        = 4'd2;
    localparam logic [CODE_W-1:0] EV_DOUBLE_FREE    = 4'd3;
    localparam logic [CODE_W-1:0] EV_UNMATCHED_FREE = 4'd4;
    localparam logic [CODE_W-1:0] EV_TABLE_FULL     = 4'd5;
    localparam logic [CODE_W-1:0] EV_LEAK           = 4'd6;
    localparam logic [CODE_W-1:0] EV_CLIENT_CLEAN   = 4'd7;
    localparam logic [CODE_W-1:0] EV_NO_RECORDS     = 4'd8;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ALLOC,
        OP_FREE,
        OP_INSERT,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [CLIENT_W-1:0] client;
        logic [ADDR_W-1:0]   address;
    } t_cell_cmd;

    // Contents of one table entry.
    typedef struct packed {
        logic                valid;
        logic [CLIENT_W-1:0] client;
        logic [ADDR_W-1:0]   address;
        logic                freed;
    } t_entry;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_NOTE,
        ST_FLUSH
    } t_state;

endpackage

`default_nettype wire

@@ rtl/allocation_leak_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Allocation leak tracker. The address table is a chain of TABLE_ENTRIES cells; an allocate
// or free request is matched against all cells at once: it is accepted, then matched and
// updated in the evaluate state, giving one result. A scan request rotates the whole chain
// once past the head cell for every client that has been seen, steps over every unseen
// client and ends with a flush of the last held result; the output side can stall it.
// A scan with no client seen goes through the evaluate state like an allocate. Entries fill
// the chain in order and are never removed; the next request is taken once the previous
// one has handed its last result to the output register.
module allocation_leak_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [altrk_pkg::CMD_W-1:0]    i_cmd,
    input  logic [altrk_pkg::CLIENT_W-1:0] i_client,
    input  logic [altrk_pkg::ADDR_W-1:0]   i_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [altrk_pkg::CODE_W-1:0]   o_event_code,
    output logic [altrk_pkg::CLIENT_W-1:0] o_client_out,
    output logic [altrk_pkg::ADDR_W-1:0]   o_address_out,
    output logic                          o_last
);
    import altrk_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TABLE_ENTRIES - 1);
    localparam logic [SCLI_W-1:0] SCLI_LAST = SCLI_W'(NUM_CLIENTS - 1);

    t_state r_state, n_state;

    // Request registers.
    logic [CMD_W-1:0]    r_cmd;
    logic [CLIENT_W-1:0] r_client;
    logic [ADDR_W-1:0]   r_address;

    // Client seen flags and scan counters.
    logic [NUM_CLIENTS-1:0] r_seen, n_seen;
    logic [SCLI_W-1:0]      r_scan_cli;
    logic [STEP_W-1:0]      r_step;
    logic                   r_any;

    // Holds a stalled evaluate result or the newest scan result, so the last is marked.
    logic                r_hold_valid;
    logic [CODE_W-1:0]   r_hold_code;
    logic [CLIENT_W-1:0] r_hold_client;
    logic [ADDR_W-1:0]   r_hold_addr;

    // Output register.
    logic                r_out_valid;
    logic [CODE_W-1:0]   r_out_code;
    logic [CLIENT_W-1:0] r_out_client;
    logic [ADDR_W-1:0]   r_out_addr;
    logic                r_out_last;

    // Cell chain.
    t_cell_cmd                w_cell_cmd;
    t_entry                   w_entry [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_match;
    logic [TABLE_ENTRIES-1:0] w_valid;
    logic [TABLE_ENTRIES-1:0] w_freed;

    // Control decoded each cycle.
    logic                w_accept;
    logic                w_client_ok;
    logic                w_out_free;
    logic                w_seen_cur;
    logic                w_step_go;
    logic                w_cand_valid;
    logic [CODE_W-1:0]   w_cand_code;
    logic [CLIENT_W-1:0] w_cand_client;
    logic [ADDR_W-1:0]   w_cand_addr;
    logic                w_hit;
    logic                w_hit_freed;
    logic                w_full;
    logic                w_eval_direct;
    logic                w_push_hold;
    logic                w_flush;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            localparam int NEXT = (g + 1) % TABLE_ENTRIES;
            logic w_prev_valid;
            if (g == 0) begin : g_head
                assign w_prev_valid = 1'b1;
            end else begin : g_body
                assign w_prev_valid = w_entry[g-1].valid;
            end
            altrk_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (w_cell_cmd),
                .i_prev_valid (w_prev_valid),
                .i_next       (w_entry[NEXT]),
                .o_entry      (w_entry[g]),
                .o_match      (w_match[g])
            );
            assign w_valid[g] = w_entry[g].valid;
            assign w_freed[g] = w_entry[g].freed;
        end
    endgenerate

    assign o_in_ready    = (r_state == ST_IDLE);
    assign w_accept      = i_in_valid && o_in_ready;
    assign w_client_ok   = ({1'b0, i_client} < (CLIENT_W + 1)'(NUM_CLIENTS));
    assign w_out_free    = !r_out_valid || i_out_ready;
    assign w_seen_cur    = r_seen[r_scan_cli];
    assign w_hit         = |w_match;
    assign w_hit_freed   = |(w_match & w_freed);
    assign w_full        = w_entry[TABLE_ENTRIES-1].valid;

    assign o_out_valid   = r_out_valid;
    assign o_event_code  = r_out_code;
    assign o_client_out  = r_out_client;
    assign o_address_out = r_out_addr;
    assign o_last        = r_out_last;

    // Result candidate, chain operation and step control.
    always_comb begin
        w_cand_valid       = 1'b0;
        w_cand_code        = EV_ALLOC_OK;
        w_cand_client      = r_client;
        w_cand_addr        = r_address;
        w_cell_cmd.op      = OP_HOLD;
        w_cell_cmd.client  = r_client;
        w_cell_cmd.address = r_address;
        w_step_go          = 1'b0;
        case (r_state)
            ST_EVAL: begin
                w_cand_valid = 1'b1;
                w_step_go    = 1'b1;
                if (r_cmd == CMD_SCAN) begin
                    w_cand_code   = EV_NO_RECORDS;
                    w_cand_client = '0;
                    w_cand_addr   = '0;
                end else if (r_cmd == CMD_ALLOC) begin
                    if (w_hit) begin
                        w_cand_code   = w_hit_freed ? EV_ALLOC_OK : EV_REALLOC_LIVE;
                        w_cell_cmd.op = OP_ALLOC;
                    end else if (w_full) begin
                        w_cand_code = EV_TABLE_FULL;
                    end else begin
                        w_cand_code   = EV_ALLOC_OK;
                        w_cell_cmd.op = OP_INSERT;
                    end
                end else begin
                    if (!w_hit) begin
                        w_cand_code = EV_UNMATCHED_FREE;
                    end else if (w_hit_freed) begin
                        w_cand_code = EV_DOUBLE_FREE;
                    end else begin
                        w_cand_code   = EV_FREE_OK;
                        w_cell_cmd.op = OP_FREE;
                    end
                end
            end
            ST_SCAN: begin
                w_cand_client = CLIENT_W'(r_scan_cli);
                w_cand_addr   = w_entry[0].address;
                w_cand_code   = EV_LEAK;
                if (!w_seen_cur) begin
                    w_step_go = 1'b1;
                end else begin
                    w_cand_valid = w_entry[0].valid && !w_entry[0].freed &&
                                   (w_entry[0].client == CLIENT_W'(r_scan_cli));
                    w_step_go    = !w_cand_valid || !r_hold_valid || w_out_free;
                    if (w_step_go) begin
                        w_cell_cmd.op = OP_ROTATE;
                    end
                end
            end
            ST_NOTE: begin
                w_cand_valid  = !r_any;
                w_cand_code   = EV_CLIENT_CLEAN;
                w_cand_client = CLIENT_W'(r_scan_cli);
                w_cand_addr   = '0;
                w_step_go     = !w_cand_valid || !r_hold_valid || w_out_free;
            end
            ST_FLUSH: begin
                w_step_go = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // Which source loads the output register.
    assign w_eval_direct = (r_state == ST_EVAL) && w_out_free;
    assign w_push_hold   = (r_state == ST_SCAN || r_state == ST_NOTE) && w_step_go &&
                           w_cand_valid && r_hold_valid;
    assign w_flush       = (r_state == ST_FLUSH) && w_out_free;

    // Client seen flags for an allocate or free.
    always_comb begin
        n_seen = r_seen;
        if (r_state == ST_EVAL && r_cmd != CMD_SCAN) begin
            for (int c = 0; c < NUM_CLIENTS; c++) begin
                if (r_client == CLIENT_W'(c)) begin
                    n_seen[c] = 1'b1;
                end
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_SCAN) begin
                        n_state = (r_seen == '0) ? ST_EVAL : ST_SCAN;
                    end else if ((i_cmd == CMD_ALLOC || i_cmd == CMD_FREE) && w_client_ok) begin
                        n_state = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                n_state = w_out_free ? ST_IDLE : ST_FLUSH;
            end
            ST_SCAN: begin
                if (!w_seen_cur) begin
                    n_state = (r_scan_cli == SCLI_LAST) ? ST_FLUSH : ST_SCAN;
                end else if (w_step_go && r_step == STEP_LAST) begin
                    n_state = ST_NOTE;
                end
            end
            ST_NOTE: begin
                if (w_step_go) begin
                    n_state = (r_scan_cli == SCLI_LAST) ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_seen       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_scan_cli   <= '0;
            r_step       <= '0;
            r_any        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;

            // Scan counters.
            if (w_accept) begin
                r_scan_cli <= '0;
                r_step     <= '0;
                r_any      <= 1'b0;
            end else if (r_state == ST_SCAN && w_step_go) begin
                if (!w_seen_cur) begin
                    r_scan_cli <= r_scan_cli + 1'b1;
                end else begin
                    r_step <= (r_step == STEP_LAST) ? '0 : r_step + 1'b1;
                    if (w_cand_valid) begin
                        r_any <= 1'b1;
                    end
                end
            end else if (r_state == ST_NOTE && w_step_go) begin
                r_scan_cli <= r_scan_cli + 1'b1;
                r_any      <= 1'b0;
            end

            // Hold stage occupancy.
            if ((r_state == ST_EVAL && !w_out_free) ||
                ((r_state == ST_SCAN || r_state == ST_NOTE) && w_step_go && w_cand_valid)) begin
                r_hold_valid <= 1'b1;
            end else if (w_flush) begin
                r_hold_valid <= 1'b0;
            end

            // Output register occupancy.
            if (w_eval_direct || w_push_hold || w_flush) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= i_cmd;
            r_client  <= i_client;
            r_address <= i_address;
        end
        if ((r_state == ST_EVAL && !w_out_free) ||
            ((r_state == ST_SCAN || r_state == ST_NOTE) && w_step_go && w_cand_valid)) begin
            r_hold_code   <= w_cand_code;
            r_hold_client <= w_cand_client;
            r_hold_addr   <= w_cand_addr;
        end
        if (w_eval_direct) begin
            r_out_code   <= w_cand_code;
            r_out_client <= w_cand_client;
            r_out_addr   <= w_cand_addr;
            r_out_last   <= 1'b1;
        end else if (w_push_hold || w_flush) begin
            r_out_code   <= r_hold_code;
            r_out_client <= r_hold_client;
            r_out_addr   <= r_hold_addr;
            r_out_last   <= w_flush;
        end
    end

    // The final flush always has a held result to deliver.
    a_flush_has_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> r_hold_valid)
        else $error("flush without a held result");

    // No held result may remain when a new request can be taken.
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_hold_valid)
        else $error("held result left over at idle");

    // When idle, the valid entries form a prefix of the chain.
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ((w_valid & (w_valid + 1'b1)) == '0))
        else $error("valid entries are not a prefix");

    // A full rotation has completed whenever a client note is issued.
    a_note_rotated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NOTE) |-> (r_step == '0))
        else $error("client note before the chain came back around");

endmodule

`default_nettype wire

@@ rtl/altrk_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module altrk_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  altrk_pkg::t_cell_cmd i_cmd,
    input  logic                i_prev_valid,
    input  altrk_pkg::t_entry   i_next,
    output altrk_pkg::t_entry   o_entry,
    output logic                o_match
);
    import altrk_pkg::*;

    logic                r_valid;
    logic [CLIENT_W-1:0] r_client;
    logic [ADDR_W-1:0]   r_address;
    logic                r_freed;
    logic                w_take;

    // This cell matches the broadcast client and address.
    assign o_match = r_valid && (r_client == i_cmd.client) && (r_address == i_cmd.address);

    // The first empty cell of the filled prefix takes an insert.
    assign w_take = !r_valid && i_prev_valid;

    assign o_entry = '{valid: r_valid, client: r_client, address: r_address, freed: r_freed};

    // Valid bit, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_INSERT: begin
                    if (w_take) begin
                        r_valid <= 1'b1;
                    end
                end
                OP_ROTATE: begin
                    r_valid <= i_next.valid;
                end
                default: begin
                end
            endcase
        end
    end

    // Entry payload.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ALLOC: begin
                if (o_match) begin
                    r_freed <= 1'b0;
                end
            end
            OP_FREE: begin
                if (o_match) begin
                    r_freed <= 1'b1;
                end
            end
            OP_INSERT: begin
                if (w_take) begin
                    r_client  <= i_cmd.client;
                    r_address <= i_cmd.address;
                    r_freed   <= 1'b0;
                end
            end
            OP_ROTATE: begin
                r_client  <= i_next.client;
                r_address <= i_next.address;
                r_freed   <= i_next.freed;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import altrk_pkg::*;

    // The one command value that the block ignores.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Size of the shared address pool and length of the long output stall.
    localparam int POOL_SIZE        = 8;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES    = (TABLE_ENTRIES + 1) * NUM_CLIENTS + 16;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [CLIENT_W-1:0] client;
        logic [ADDR_W-1:0]   address;
        logic                last;
    } t_report;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [CMD_W-1:0]    i_cmd;
    logic [CLIENT_W-1:0] i_client;
    logic [ADDR_W-1:0]   i_address;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [CODE_W-1:0]   o_event_code;
    logic [CLIENT_W-1:0] o_client_out;
    logic [ADDR_W-1:0]   o_address_out;
    logic                o_last;

    // Tracker state as the testbench sees it.
    bit                  tbl_valid [TABLE_ENTRIES];
    logic [CLIENT_W-1:0] tbl_client [TABLE_ENTRIES];
    logic [ADDR_W-1:0]   tbl_addr [TABLE_ENTRIES];
    bit                  tbl_freed [TABLE_ENTRIES];
    bit [NUM_CLIENTS-1:0] seen_mask;

    t_report           pending_results[$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    int                mismatch_count;
    bit                idle_off;
    bit                hold_request;

    allocation_leak_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_client      (i_client),
        .i_address     (i_address),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_code  (o_event_code),
        .o_client_out  (o_client_out),
        .o_address_out (o_address_out),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic void push_report(input logic [CODE_W-1:0] code,
                                        input logic [CLIENT_W-1:0] cl,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic last);
        t_report r;
        r.code    = code;
        r.client  = cl;
        r.address = addr;
        r.last    = last;
        pending_results.push_back(r);
    endfunction

    // Apply one accepted request to the table and queue the results it causes.
    function automatic void track_event(input logic [CMD_W-1:0] cmd,
                                        input logic [CLIENT_W-1:0] cl,
                                        input logic [ADDR_W-1:0] addr);
        int      hit;
        int      slot;
        bit      any_live;
        t_report tail;
        hit  = -1;
        slot = -1;
        if (cmd == CMD_SCAN) begin
            if (seen_mask == '0) begin
                push_report(EV_NO_RECORDS, '0, '0, 1'b1);
                return;
            end
            for (int c = 0; c < NUM_CLIENTS; c++) begin
                if (!seen_mask[c]) continue;
                any_live = 1'b0;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (tbl_valid[i] && tbl_client[i] == CLIENT_W'(c) && !tbl_freed[i]) begin
                        push_report(EV_LEAK, CLIENT_W'(c), tbl_addr[i], 1'b0);
                        any_live = 1'b1;
                    end
                end
                if (!any_live) push_report(EV_CLIENT_CLEAN, CLIENT_W'(c), '0, 1'b0);
            end
            // The final result of the scan carries the last flag.
            tail = pending_results[$];
            pending_results.pop_back();
            tail.last = 1'b1;
            pending_results.push_back(tail);
            return;
        end
        if (cmd == CMD_UNUSED || int'(cl) >= NUM_CLIENTS) return;

        seen_mask[cl] = 1'b1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_client[i] == cl && tbl_addr[i] == addr) hit = i;
        end

        if (cmd == CMD_ALLOC) begin
            if (hit >= 0) begin
                push_report(tbl_freed[hit] ? EV_ALLOC_OK : EV_REALLOC_LIVE, cl, addr, 1'b1);
                tbl_freed[hit] = 1'b0;
                return;
            end
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot < 0 && !tbl_valid[i]) slot = i;
            end
            if (slot < 0) begin
                push_report(EV_TABLE_FULL, cl, addr, 1'b1);
                return;
            end
            tbl_valid[slot]  = 1'b1;
            tbl_client[slot] = cl;
            tbl_addr[slot]   = addr;
            tbl_freed[slot]  = 1'b0;
            push_report(EV_ALLOC_OK, cl, addr, 1'b1);
            return;
        end

        if (hit < 0) begin
            push_report(EV_UNMATCHED_FREE, cl, addr, 1'b1);
        end else if (tbl_freed[hit]) begin
            push_report(EV_DOUBLE_FREE, cl, addr, 1'b1);
        end else begin
            tbl_freed[hit] = 1'b1;
            push_report(EV_FREE_OK, cl, addr, 1'b1);
        end
    endfunction

    function automatic void note_mismatch(input string what, input t_report want,
                                          input t_report got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t %s: expected code %0d client %0d address %h last %0b,",
                     $time, what, want.code, want.client, want.address, want.last);
            $display("    got code %0d client %0d address %h last %0b",
                     got.code, got.client, got.address, got.last);
        end
    endfunction

    // Send one request, possibly after a short gap, and wait until it is taken.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CLIENT_W-1:0] cl,
                                input logic [ADDR_W-1:0] addr);
        if (!idle_off && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_client   <= cl;
        i_address  <= addr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        track_event(cmd, cl, addr);
    endtask

    // Stop offering requests until every queued result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Random request: mostly allocate and free over a small pool, some scans.
    task automatic send_random_event(input bit fresh_share);
        int                  pick;
        logic [CMD_W-1:0]    cmd;
        logic [ADDR_W-1:0]   addr;
        pick = $urandom_range(0, 19);
        if (pick < 9)       cmd = CMD_ALLOC;
        else if (pick < 17) cmd = CMD_FREE;
        else if (pick < 19) cmd = CMD_SCAN;
        else                cmd = CMD_UNUSED;
        if (fresh_share && $urandom_range(0, 3) == 0) addr = {$urandom, $urandom};
        else addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        send_request(cmd, CLIENT_W'($urandom_range(0, NUM_CLIENTS - 1)), addr);
    endtask

    // Scans before any client is seen; the unused command must not mark a client.
    task automatic test_empty_scan();
        send_request(CMD_SCAN, 2'd1, '1);
        send_request(CMD_UNUSED, 2'd2, 64'h0123_4567_89ab_cdef);
        send_request(CMD_SCAN, '0, '0);
    endtask

    // Each result code but table full and no records, from a short hand-written sequence.
    task automatic test_single_events();
        send_request(CMD_ALLOC, 2'd0, '0);
        send_request(CMD_ALLOC, 2'd3, '1);
        send_request(CMD_ALLOC, 2'd0, '0);
        send_request(CMD_ALLOC, 2'd1, '0);
        send_request(CMD_FREE, 2'd0, '0);
        send_request(CMD_FREE, 2'd0, '0);
        send_request(CMD_FREE, 2'd2, 64'h5555_aaaa_5555_aaaa);
        send_request(CMD_ALLOC, 2'd0, '0);
        send_request(CMD_UNUSED, 2'd1, '1);
        send_request(CMD_SCAN, 2'd3, '1);
        send_request(CMD_FREE, 2'd3, '1);
        send_request(CMD_FREE, 2'd1, '0);
        send_request(CMD_SCAN, '0, '0);
    endtask

    // Random traffic with a long output stall and a full drain in the middle.
    task automatic test_random_traffic();
        for (int n = 0; n < 60; n++) begin
            if (n == 20) hold_request = 1'b1;
            if (n == 40) wait_drained();
            send_random_event(1'b0);
        end
    endtask

    // Fill every free entry, then hit the full table, a realloc and the frees.
    task automatic test_table_full();
        int free_slots;
        free_slots = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!tbl_valid[i]) free_slots++;
        end
        repeat (free_slots + 2) begin
            send_request(CMD_ALLOC, CLIENT_W'($urandom_range(0, NUM_CLIENTS - 1)),
                         {$urandom, $urandom});
        end
        send_request(CMD_ALLOC, tbl_client[TABLE_ENTRIES-1], tbl_addr[TABLE_ENTRIES-1]);
        send_request(CMD_FREE, tbl_client[TABLE_ENTRIES-1], tbl_addr[TABLE_ENTRIES-1]);
        send_request(CMD_FREE, tbl_client[TABLE_ENTRIES-1], tbl_addr[TABLE_ENTRIES-1]);
        send_request(CMD_SCAN, '0, '0);
        send_request(CMD_ALLOC, tbl_client[0], ~tbl_addr[0]);
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_final_burst();
        wait_drained();
        idle_off = 1'b1;
        repeat (30) send_random_event(1'b1);
        send_request(CMD_SCAN, '0, '0);
    endtask

    // Output side: random stall bursts, plus one long stall on request.
    initial begin : out_side
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                i_out_ready <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 7) == 0) begin
                idle_left = $urandom_range(1, 10) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest queued one.
    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.code    = o_event_code;
            got.client  = o_client_out;
            got.address = o_address_out;
            got.last    = o_last;
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.code !== want.code || got.client !== want.client ||
                    got.address !== want.address || got.last !== want.last) begin
                    note_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        idle_off       = 1'b0;
        hold_request   = 1'b0;
        seen_mask      = '0;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_cmd      <= CMD_ALLOC;
        i_client   <= '0;
        i_address  <= '0;

        // The pool always holds both extreme addresses.
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = {$urandom, $urandom};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_scan();
        test_single_events();
        test_random_traffic();
        test_table_full();
        test_final_burst();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
